[rtl/core/wfd_pkg.sv]
package wfd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_valid;
		logic       frame_end;
		logic [1:0] status;
	} out_t;

	localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
	localparam logic [1:0] STATUS_REJECTED  = 2'd1;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

	localparam logic [7:0] FIN_BIT      = 8'h80;
	localparam logic [7:0] MASK_BIT     = 8'h80;
	localparam logic [7:0] OPCODE_MASK  = 8'h0F;
	localparam logic [7:0] LEN7_MASK    = 8'h7F;
	localparam logic [3:0] OPCODE_TEXT  = 4'd1;
	localparam logic [6:0] LEN7_EXT16   = 7'd126;
	localparam logic [6:0] LEN7_EXT64   = 7'd127;
	localparam logic [3:0] EXT16_BYTES  = 4'd2;
	localparam logic [3:0] EXT64_BYTES  = 4'd8;
	localparam logic [3:0] KEY_BYTES    = 4'd4;

endpackage

[rtl/core/websocket_frame_decoder_unit.sv]
// WebSocket frame decoder, receive side, one frame per buffer.
// rx channel: one buffer byte per beat, end_of_buffer set on its last byte.
// dec channel: a beat for every payload byte (byte_valid) and one for the
// buffer's last byte (frame_end, with status complete / rejected / truncated).
// Header bytes, key bytes and bytes after the payload give no beat unless they
// close the buffer. A truncated frame is flagged only at its end, so the
// consumer drops the bytes it has already taken.
// A result appears on dec in the cycle after its byte is taken on rx.
// Throughput: one byte per cycle while dec is not stalled; the header parse,
// key XOR and the LENGTH_BITS-wide length decrement are all combinational
// between the rx handshake and the result register.
// The result register is the only buffer: while dec is stalled with a beat
// held, rx_ready drops; when the held beat is taken in the same cycle, a new
// byte is taken too.
// Reset clears the parser to the first header byte and empties the result
// register. After each buffer's last byte the parser returns to that state.
module websocket_frame_decoder_unit #(
	parameter int LENGTH_BITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         rx_valid,
	output logic         rx_ready,
	input  wfd_pkg::in_t rx_data,
	output logic         dec_valid,
	input  logic         dec_ready,
	output wfd_pkg::out_t dec_data
);
	import wfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT16,
		PH_EXT64,
		PH_KEY,
		PH_PAY,
		PH_DONE
	} phase_t;

	phase_t                 phase_q,   phase_d;
	logic [3:0]             hcnt_q,    hcnt_d;
	logic [LENGTH_BITS-1:0] remain_q,  remain_d;
	logic [1:0]             pidx_q,    pidx_d;
	logic [31:0]            key_q,     key_d;
	logic                   masked_q,  masked_d;
	logic                   reject_q,  reject_d;

	out_t                   res;
	logic                   res_en;
	logic                   accept;
	logic [7:0]             b;
	logic [3:0]             hcnt_inc;
	logic [7:0]             key_byte;

	assign accept   = rx_valid && rx_ready;
	assign rx_ready = !dec_valid || dec_ready;
	assign b        = rx_data.data_byte;
	assign hcnt_inc = hcnt_q + 4'd1;

	always_comb begin
		unique case (pidx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		hcnt_d   = hcnt_q;
		remain_d = remain_q;
		pidx_d   = pidx_q;
		key_d    = key_q;
		masked_d = masked_q;
		reject_d = reject_q;
		res      = '0;

		unique case (phase_q)
			PH_HDR0: begin
				if ((b & FIN_BIT) == 8'd0 || (b & OPCODE_MASK) != {4'd0, OPCODE_TEXT}) begin
					reject_d = 1'b1;
					phase_d  = PH_DONE;
				end else begin
					phase_d = PH_HDR1;
				end
			end
			PH_HDR1: begin
				masked_d = (b & MASK_BIT) != 8'd0;
				hcnt_d   = 4'd0;
				remain_d = '0;
				if (b[6:0] == LEN7_EXT16) begin
					phase_d = PH_EXT16;
				end else if (b[6:0] == LEN7_EXT64) begin
					phase_d = PH_EXT64;
				end else begin
					remain_d = LENGTH_BITS'(b & LEN7_MASK);
					if (masked_d)
						phase_d = PH_KEY;
					else
						phase_d = (remain_d != '0) ? PH_PAY : PH_DONE;
				end
			end
			PH_EXT16, PH_EXT64: begin
				// saturate once another byte would push bits off the top
				if (remain_q[LENGTH_BITS-1 -: 8] != 8'd0)
					remain_d = '1;
				else
					remain_d = {remain_q[LENGTH_BITS-9:0], b};
				hcnt_d = hcnt_inc;
				if (hcnt_inc == ((phase_q == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
					hcnt_d = 4'd0;
					if (masked_q)
						phase_d = PH_KEY;
					else
						phase_d = (remain_d != '0) ? PH_PAY : PH_DONE;
				end
			end
			PH_KEY: begin
				key_d  = {key_q[23:0], b};
				hcnt_d = hcnt_inc;
				if (hcnt_inc == KEY_BYTES) begin
					hcnt_d  = 4'd0;
					pidx_d  = 2'd0;
					phase_d = (remain_q != '0) ? PH_PAY : PH_DONE;
				end
			end
			PH_PAY: begin
				res.payload_byte = masked_q ? (b ^ key_byte) : b;
				res.byte_valid   = 1'b1;
				pidx_d           = pidx_q + 2'd1;
				remain_d         = remain_q - LENGTH_BITS'(1);
				if (remain_d == '0)
					phase_d = PH_DONE;
			end
			default: begin
			end
		endcase

		if (rx_data.end_of_buffer) begin
			res.frame_end = 1'b1;
			priority if (reject_d)
				res.status = STATUS_REJECTED;
			else if (phase_d == PH_DONE)
				res.status = STATUS_COMPLETE;
			else
				res.status = STATUS_TRUNCATED;
		end
	end

	assign res_en = res.byte_valid || res.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			hcnt_q    <= 4'd0;
			remain_q  <= '0;
			pidx_q    <= 2'd0;
			key_q     <= 32'd0;
			masked_q  <= 1'b0;
			reject_q  <= 1'b0;
			dec_valid <= 1'b0;
			dec_data  <= '0;
		end else begin
			if (dec_valid && dec_ready)
				dec_valid <= 1'b0;
			if (accept) begin
				if (res_en) begin
					dec_valid <= 1'b1;
					dec_data  <= res;
				end
				if (rx_data.end_of_buffer) begin
					// back to the first header byte for the next buffer
					phase_q  <= PH_HDR0;
					hcnt_q   <= 4'd0;
					remain_q <= '0;
					pidx_q   <= 2'd0;
					key_q    <= 32'd0;
					masked_q <= 1'b0;
					reject_q <= 1'b0;
				end else begin
					phase_q  <= phase_d;
					hcnt_q   <= hcnt_d;
					remain_q <= remain_d;
					pidx_q   <= pidx_d;
					key_q    <= key_d;
					masked_q <= masked_d;
					reject_q <= reject_d;
				end
			end
		end
	end

endmodule

[rtl/core/wfd_checker.sv]
module wfd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rx_valid,
	input logic          rx_ready,
	input wfd_pkg::in_t  rx_data,
	input logic          dec_valid,
	input logic          dec_ready,
	input wfd_pkg::out_t dec_data
);
	import wfd_pkg::*;

	// no beat may come out of reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !dec_valid)
		else $error("dec_valid high during reset");

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_ready |=> dec_valid && $stable(dec_data))
		else $error("stalled dec beat changed");

	// with the result register full and stalled, take no byte
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_ready |-> !rx_ready)
		else $error("rx taken while dec stalled");

	// every beat carries a byte or closes the buffer; status only at the end
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid |-> (dec_data.byte_valid || dec_data.frame_end) &&
			(dec_data.frame_end || dec_data.status == STATUS_COMPLETE))
		else $error("malformed dec beat");

	// a buffer's last byte always yields a closing beat in the next cycle
	a_end_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready && rx_data.end_of_buffer |=> dec_valid && dec_data.frame_end)
		else $error("missing frame_end beat");

endmodule

bind websocket_frame_decoder_unit wfd_checker u_wfd_checker (.*);
